// ===== rtl/core/session_packet_rx_check_assert.svh =====
// Assertion macros used by the checker in spr_checker.sv.
`ifndef SESSION_PACKET_RX_CHECK_ASSERT_SVH
`define SESSION_PACKET_RX_CHECK_ASSERT_SVH

// Holds at every clock edge outside reset.
`define SPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SPR_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/spr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

	localparam int HDR_BYTES  = 13;
	localparam int TAIL_BYTES = 4;
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam int TDATA_W   = 120;
	localparam int TUSER_W   = 3;
	localparam int TYPE_LSB  = 0;
	localparam int RETX_LSB  = 7;
	localparam int SRC_LSB   = 15;
	localparam int DST_LSB   = 23;
	localparam int CHAN_LSB  = 31;
	localparam int FRAG_LSB  = 39;
	localparam int PID_LSB   = 55;
	localparam int TS_LSB    = 71;
	localparam int BODY_LSB  = 103;
	localparam int STATUS_LSB = 0;
	localparam int HASCRC_BIT = 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_TYPE = 2'd1,
		ST_BAD_CRC  = 2'd2,
		ST_SHORT    = 2'd3
	} status_t;

	// Packet record passed from front to back on the last byte.
	typedef struct packed {
		logic [12:0][7:0] hdr;
		logic             flag;
		logic [15:0]      pos;
		logic [31:0]      crc_calc;
		logic [31:0]      crc_rx;
	} rec_t;

	typedef struct packed {
		status_t            status;
		logic               has_crc;
		logic [6:0]         packet_type;
		logic [7:0]         retransmit_count;
		logic [7:0]         src_connection;
		logic [7:0]         dst_connection;
		logic [7:0]         channel;
		logic signed [15:0] fragment_id;
		logic [15:0]        packet_id;
		logic [31:0]        send_timestamp;
		logic [15:0]        body_length;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/session_packet_rx_check.sv =====
// Received datagram checker. Bytes enter on the slave stream one per cycle
// while s_tready is high (s_tdata[7:0], s_tlast on the final byte); the
// 13-byte header is unpacked, a CRC-32C over all bytes but a trailing
// four-byte CRC is checked when header bit 7 is set, and one result transfer
// leaves on the master stream per packet. Throughput is one byte per clock while
// s_tready is high, set by the byte-wide CRC update in the front stage. The
// last byte's record passes the result queue, then the output register (m_tvalid).
// A two-entry result queue sits between the byte front end and the output
// register, so s_tready only drops when the queue holds two finished results
// behind a stalled output register (three results waiting in all).
// type_limit is written over cfg_* (reset value 8); the user must write it only
// while no packet is in flight, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module session_packet_rx_check (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // data_byte
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// packet_type, retransmit_count, src_connection, dst_connection, channel,
	// fragment_id, packet_id, send_timestamp, body_length, zero pad
	output logic [119:0]      m_tdata,
	output logic [2:0]        m_tuser,   // status, has_crc
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_data
);

	logic             take;
	logic             push;
	spr_pkg::rec_t    push_rec;
	logic             q_full;
	logic             q_valid;
	logic             q_pop;
	spr_pkg::rec_t    q_rec;
	spr_pkg::result_t res;
	logic [7:0]       type_limit_q;

	assign s_tready  = !q_full;
	assign take      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_limit_q <= 8'd8;
		end else if (cfg_valid) begin
			type_limit_q <= cfg_data;
		end
	end

	spr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_tdata),
		.last_byte (s_tlast),
		.push      (push),
		.rec       (push_rec)
	);

	spr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.rd_rec   (q_rec)
	);

	spr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.type_limit (type_limit_q),
		.q_valid    (q_valid),
		.q_rec      (q_rec),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	assign m_tdata = {1'b0, res.body_length, res.send_timestamp, res.packet_id,
	                  res.fragment_id, res.channel, res.dst_connection,
	                  res.src_connection, res.retransmit_count, res.packet_type};
	assign m_tuser = {res.has_crc, res.status};

endmodule

`default_nettype wire

// ===== rtl/core/spr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spr_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire spr_pkg::rec_t push_rec,
	output logic              full,
	input  wire logic         pop,
	output logic              valid,
	output spr_pkg::rec_t     rd_rec
);

	localparam int Depth = 2;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	spr_pkg::rec_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full   = (count_q == CntW'(Depth));
	assign valid  = (count_q != '0);
	assign rd_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/spr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spr_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             push,
	output spr_pkg::rec_t    rec
);

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ spr_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [15:0]      count_q;
	logic [12:0][7:0] hdr_q;
	logic [3:0][7:0]  tail_q;
	logic [31:0]      crc_q;
	logic             flag_q;

	logic [12:0][7:0] hdr_next;
	logic [3:0][7:0]  tail_next;
	logic [31:0]      crc_next;
	logic             flag_next;
	logic [15:0]      count_next;

	always_comb begin
		hdr_next = hdr_q;
		if (count_q < 16'(spr_pkg::HDR_BYTES)) begin
			hdr_next[count_q[3:0]] = data_byte;
		end
		flag_next  = (count_q == '0) ? data_byte[7] : flag_q;
		crc_next   = (count_q >= 16'(spr_pkg::TAIL_BYTES)) ? crc32c_byte(crc_q, tail_q[0]) : crc_q;
		tail_next  = {data_byte, tail_q[3:1]};
		count_next = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
	end

	assign push          = take && last_byte;
	assign rec.hdr       = hdr_next;
	assign rec.flag      = flag_next;
	assign rec.pos       = count_q;
	assign rec.crc_calc  = crc_next;
	assign rec.crc_rx    = tail_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hdr_q   <= '0;
			tail_q  <= '0;
			crc_q   <= spr_pkg::CRC_INIT;
			flag_q  <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				count_q <= '0;
				hdr_q   <= '0;
				tail_q  <= '0;
				crc_q   <= spr_pkg::CRC_INIT;
				flag_q  <= 1'b0;
			end else begin
				count_q <= count_next;
				hdr_q   <= hdr_next;
				tail_q  <= tail_next;
				crc_q   <= crc_next;
				flag_q  <= flag_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/spr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    type_limit,
	input  wire logic          q_valid,
	input  wire spr_pkg::rec_t q_rec,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output spr_pkg::result_t   out_res
);

	logic             valid_q;
	spr_pkg::result_t res_q;
	spr_pkg::result_t res;
	logic [6:0]       ptype;
	logic [16:0]      total;
	logic [16:0]      overhead;
	logic [16:0]      body_raw;

	always_comb begin
		ptype    = q_rec.hdr[0][6:0];
		total    = {1'b0, q_rec.pos} + 17'd1;
		overhead = q_rec.flag ? 17'(spr_pkg::HDR_BYTES + spr_pkg::TAIL_BYTES)
		                      : 17'(spr_pkg::HDR_BYTES);
		body_raw = total - overhead;

		res.status           = spr_pkg::ST_OK;
		res.has_crc          = q_rec.flag;
		res.packet_type      = ptype;
		res.retransmit_count = q_rec.hdr[1];
		res.src_connection   = q_rec.hdr[2];
		res.dst_connection   = q_rec.hdr[3];
		res.channel          = q_rec.hdr[4];
		res.fragment_id      = {q_rec.hdr[6], q_rec.hdr[5]};
		res.packet_id        = {q_rec.hdr[8], q_rec.hdr[7]};
		res.send_timestamp   = {q_rec.hdr[12], q_rec.hdr[11], q_rec.hdr[10], q_rec.hdr[9]};
		res.body_length      = '0;

		if ({1'b0, ptype} >= type_limit) begin
			res.status           = spr_pkg::ST_BAD_TYPE;
			res.retransmit_count = '0;
			res.src_connection   = '0;
			res.dst_connection   = '0;
			res.channel          = '0;
			res.fragment_id      = '0;
			res.packet_id        = '0;
			res.send_timestamp   = '0;
		end else if (total < overhead) begin
			res.status = spr_pkg::ST_SHORT;
		end else begin
			res.body_length = (q_rec.pos == 16'hFFFF) ? 16'hFFFF : body_raw[15:0];
			if (q_rec.flag && ((q_rec.crc_calc ^ spr_pkg::CRC_INIT) != q_rec.crc_rx)) begin
				res.status = spr_pkg::ST_BAD_CRC;
			end
		end
	end

	assign q_pop     = q_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/spr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "session_packet_rx_check_assert.svh"

module spr_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [119:0] m_tdata,
	input wire logic [2:0]   m_tuser
);

	logic [1:0] st;

	assign st = m_tuser[spr_pkg::STATUS_LSB +: 2];

	`SPR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`SPR_ASSERT(a_bad_type_zero, !(m_tvalid && st == spr_pkg::ST_BAD_TYPE) || m_tdata[118:spr_pkg::RETX_LSB] == '0, "bad type result carries header data")
	`SPR_ASSERT(a_short_no_body, !(m_tvalid && st == spr_pkg::ST_SHORT) || m_tdata[spr_pkg::BODY_LSB +: 16] == '0, "short packet reports a body")
	`SPR_ASSERT(a_crc_err_flag, !(m_tvalid && st == spr_pkg::ST_BAD_CRC) || m_tuser[spr_pkg::HASCRC_BIT], "checksum error without CRC flag")

endmodule

bind session_packet_rx_check spr_checker u_checker (.*);

`default_nettype wire
